// File: hdl/tdmcu_pkg.sv
// Shared constants and types for the TDM channel usage counter.
`timescale 1ns / 1ps
`default_nettype none
package tdmcu_pkg;

  // Ratio choices per direction and the bin memory built from them
  localparam int NUM_RATIOS  = 256;
  localparam int MAX_SIGNALS = 4096;
  localparam int RATIO_W     = $clog2(NUM_RATIOS);
  localparam int ADDR_W      = RATIO_W + 1;
  localparam int BIN_DEPTH   = 2 ** ADDR_W;

  // Field widths
  localparam int IDX_W   = 8;
  localparam int LIMIT_W = 16;
  localparam int COUNT_W = 13;
  localparam int USAGE_W = 14;

  // Count saturation point: the smaller of MAX_SIGNALS and the 13-bit maximum
  localparam int COUNT_MAX = 2 ** COUNT_W - 1;
  localparam int COUNT_CAP = (MAX_SIGNALS < COUNT_MAX) ? MAX_SIGNALS : COUNT_MAX;
  localparam int USAGE_MAX = 2 ** USAGE_W - 1;

  // Divider: dividend is ceil(count/8) + k - 1, quotient as wide
  localparam int DIVD_W = 12;

  typedef struct packed {
    logic                start;
    logic [DIVD_W-1:0]   dividend;
    logic [RATIO_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIVD_W-1:0]   quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: hdl/tdm_channel_usage_counter.sv
// Top level: per-bin signal histogram and wire usage walk for one TDM channel.
//
// Each input word counts one signal into a bin picked by direction and ratio
// choice; a word goes through accept, bin read and bin write before the next
// is taken, limited by the single-port read-modify-write of the 512-entry bin
// memory. On the word marked tlast the sequencer then walks all 512 bins: a bin
// that is empty or has ratio 1 or 8 is added directly, other bins go through
// the shared bit-serial divider. The walk clears each bin as it reads it, and
// the result (wires used, overshoot over wire_limit) goes to an output register
// that frees the input side. After reset a clearing pass over all 512 bins runs
// before the first input word is taken; wire_limit writes are taken any time.
`timescale 1ns / 1ps
`default_nettype none
module tdm_channel_usage_counter
  import tdmcu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ratio_index
  input  wire logic [0:0]  in_tuser,   // [0] forward
  input  wire logic        in_tlast,   // last_signal
  // Result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [13:0] wires_used, [27:14] overshoot
  // wire_limit register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_INC, ST_WK_RD, ST_WK_EVAL, ST_WK_DIV, ST_DONE
  } state_t;

  localparam logic [ADDR_W-1:0]  LAST_BIN = {1'b1, RATIO_W'(NUM_RATIOS - 1)};
  localparam logic [RATIO_W-1:0] K_LAST   = RATIO_W'(NUM_RATIOS - 1);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                last_r, last_nxt;
  logic [USAGE_W-1:0]  acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [USAGE_W-1:0]  out_used_r, out_used_nxt;
  logic [USAGE_W-1:0]  out_over_r, out_over_nxt;
  logic [LIMIT_W-1:0]  limit_r;

  logic [COUNT_W-1:0]  bin_mem [BIN_DEPTH];
  logic [COUNT_W-1:0]  rd_data_r;
  logic                mem_we;
  logic [COUNT_W-1:0]  mem_wd;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                div_start;

  logic [RATIO_W-1:0]  choice;
  logic [RATIO_W-1:0]  walk_k;
  logic [COUNT_W:0]    ceil8_sum;
  logic [COUNT_W-1:0]  term;
  logic                direct;
  logic [USAGE_W-1:0]  add_val;
  logic                add_en;
  logic [USAGE_W:0]    acc_sum;
  logic [USAGE_W-1:0]  acc_sat;
  logic [ADDR_W-1:0]   addr_step;
  logic                in_acc;

  assign in_acc = in_tvalid && in_tready;

  // Ratio choice, clamped to the largest one
  always_comb begin
    if (32'(in_tdata) >= NUM_RATIOS) begin
      choice = K_LAST;
    end else begin
      choice = RATIO_W'(in_tdata);
    end
  end

  // Per-bin term: count, ceil(count/8), or through the divider
  always_comb begin
    walk_k    = addr_r[RATIO_W-1:0];
    ceil8_sum = {1'b0, rd_data_r} + (COUNT_W + 1)'(7);
    direct    = (rd_data_r == '0) || (walk_k == '0) || (walk_k == RATIO_W'(1));
    if (walk_k == '0) begin
      term = rd_data_r;
    end else begin
      term = COUNT_W'(ceil8_sum >> 3);
    end
    div_req.start    = div_start;
    div_req.dividend = DIVD_W'(ceil8_sum >> 3) + DIVD_W'(walk_k) - DIVD_W'(1);
    div_req.divisor  = walk_k;
  end

  // Saturating accumulate
  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, add_val};
    if (acc_sum > (USAGE_W + 1)'(USAGE_MAX)) begin
      acc_sat = USAGE_W'(USAGE_MAX);
    end else begin
      acc_sat = acc_sum[USAGE_W-1:0];
    end
  end

  // Next bin in walk order
  always_comb begin
    if (walk_k == K_LAST) begin
      addr_step = {1'b1, {RATIO_W{1'b0}}};
    end else begin
      addr_step = addr_r + 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_used_nxt  = out_used_r;
    out_over_nxt  = out_over_r;
    mem_we        = 1'b0;
    mem_wd        = '0;
    div_start     = 1'b0;
    add_val       = '0;
    add_en        = 1'b0;
    in_tready     = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == ADDR_W'(BIN_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          addr_nxt  = {in_tuser[0], choice};
          last_nxt  = in_tlast;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_INC;
      end
      ST_INC: begin
        mem_we = 1'b1;
        if (rd_data_r < COUNT_W'(COUNT_CAP)) begin
          mem_wd = rd_data_r + 1'b1;
        end else begin
          mem_wd = rd_data_r;
        end
        if (last_r) begin
          addr_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = ST_WK_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WK_RD: begin
        state_nxt = ST_WK_EVAL;
      end
      ST_WK_EVAL: begin
        mem_we = 1'b1;
        if (direct) begin
          add_val = USAGE_W'(term);
          add_en  = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_WK_DIV;
        end
      end
      ST_WK_DIV: begin
        if (div_rsp.done) begin
          add_val = USAGE_W'(div_rsp.quotient);
          add_en  = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_used_nxt  = acc_r;
          if ({{(LIMIT_W - USAGE_W){1'b0}}, acc_r} > limit_r) begin
            out_over_nxt = USAGE_W'({{(LIMIT_W - USAGE_W){1'b0}}, acc_r} - limit_r);
          end else begin
            out_over_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // Bin finished: accumulate and move on
    if (add_en) begin
      acc_nxt = acc_sat;
      if (addr_r == LAST_BIN) begin
        state_nxt = ST_DONE;
      end else begin
        addr_nxt  = addr_step;
        state_nxt = ST_WK_RD;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      last_r      <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      last_r      <= last_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_used_r <= out_used_nxt;
    out_over_r <= out_over_nxt;
  end

  // wire_limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // Bin memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[addr_r] <= mem_wd;
    end
    rd_data_r <= bin_mem[addr_r];
  end

  tdmcu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - 2 * USAGE_W){1'b0}}, out_over_r, out_used_r};

endmodule
`default_nettype wire

// File: hdl/tdmcu_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tdmcu_div
  import tdmcu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0]  quo_r;
  logic [RATIO_W-1:0] rem_r;
  logic [RATIO_W-1:0] dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [RATIO_W:0]   trial;
  logic               fits;
  logic [RATIO_W:0]   diff;

  // One trial subtract per cycle
  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    fits  = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], fits};
      rem_r <= fits ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// File: hdl/tdmcu_checker.sv
// Port-level checks for the TDM channel usage counter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tdmcu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // Overshoot never exceeds usage
  a_over_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[27:14] <= out_tdata[13:0]))
    else $error("overshoot above wires_used");

  // Pad bits of a result word stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:28] == 4'd0))
    else $error("nonzero pad bits in result word");

  // The bin update keeps the input closed right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after accept");

  // A word without tlast never raises a result
  a_no_result_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tlast) |=> !$rose(out_tvalid))
    else $error("result raised by a word without tlast");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

endmodule

bind tdm_channel_usage_counter tdmcu_checker u_tdmcu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
